// ===== design/point_in_polygon_test_assert.svh =====
// Assertion macros for the point-in-polygon test block.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

`ifndef SYNTH
`define PIP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("point_in_polygon_test: assertion failed");
`define PIP_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("point_in_polygon_test: forbidden condition seen");
`else
`define PIP_ASSERT(lbl, prop)
`define PIP_NEVER(lbl, expr)
`endif

`endif

// ===== design/pip_pkg.sv =====
// Shared constants, types and codes for the point-in-polygon test block.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEST   = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // Status of the edge pipeline seen by the controller.
    typedef struct packed {
        logic idle;
        logic odd;
    } edge_stat_t;

endpackage

// ===== design/pip_edge_unit.sv =====
// Two-stage edge pipeline: straddle check, exact crossing compare, parity.
module pip_edge_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                pair_vld,
    input  pip_pkg::coord_t     qx,
    input  pip_pkg::coord_t     qy,
    input  pip_pkg::coord_t     xi,
    input  pip_pkg::coord_t     yi,
    input  pip_pkg::coord_t     xj,
    input  pip_pkg::coord_t     yj,
    output pip_pkg::edge_stat_t stat
);
    import pip_pkg::*;

    logic  a_vld_reg, a_vld_next;
    logic  a_str_reg, a_str_next;
    logic  a_pos_reg, a_pos_next;
    diff_t a_dxq_reg, a_dxq_next;
    diff_t a_dy_reg,  a_dy_next;
    diff_t a_dxe_reg, a_dxe_next;
    diff_t a_dqy_reg, a_dqy_next;

    logic  b_vld_reg, b_vld_next;
    logic  b_str_reg, b_str_next;
    logic  b_pos_reg, b_pos_next;
    prod_t b_lhs_reg, b_lhs_next;
    prod_t b_rhs_reg, b_rhs_next;

    logic  inside_reg, inside_next;
    logic  left;

    always_comb
    begin
        // Stage A: differences and the straddle test.
        a_vld_next = pair_vld;
        a_str_next = (yi > qy) != (yj > qy);
        a_pos_next = yj > yi;
        a_dxq_next = diff_t'(qx) - diff_t'(xi);
        a_dy_next  = diff_t'(yj) - diff_t'(yi);
        a_dxe_next = diff_t'(xj) - diff_t'(xi);
        a_dqy_next = diff_t'(qy) - diff_t'(yi);

        // Stage B: cross-multiply instead of dividing by dy.
        b_vld_next = a_vld_reg;
        b_str_next = a_str_reg;
        b_pos_next = a_pos_reg;
        b_lhs_next = a_dxq_reg * a_dy_reg;
        b_rhs_next = a_dxe_reg * a_dqy_reg;

        // Flip the compare when dy is negative.
        left = b_pos_reg ? (b_lhs_reg < b_rhs_reg) : (b_lhs_reg > b_rhs_reg);
        inside_next = inside_reg;
        if (clear)
        begin
            inside_next = 1'b0;
        end
        else if (b_vld_reg && b_str_reg && left)
        begin
            inside_next = !inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg  <= a_vld_next;
            b_vld_reg  <= b_vld_next;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_str_reg <= a_str_next;
        a_pos_reg <= a_pos_next;
        a_dxq_reg <= a_dxq_next;
        a_dy_reg  <= a_dy_next;
        a_dxe_reg <= a_dxe_next;
        a_dqy_reg <= a_dqy_next;
        b_str_reg <= b_str_next;
        b_pos_reg <= b_pos_next;
        b_lhs_reg <= b_lhs_next;
        b_rhs_reg <= b_rhs_next;
    end

    assign stat.idle = !a_vld_reg && !b_vld_reg;
    assign stat.odd  = inside_reg;

endmodule

// ===== design/point_in_polygon_test.sv =====
// Point-in-polygon test by the even-odd crossing rule over one stored polygon.
// A transaction is taken when start is high and busy is low. Start and append
// transactions finish in the cycle they are taken; busy stays low. A test
// against an empty polygon answers outside on done in the next cycle without
// raising busy. Any other test holds busy while the vertex memory is read once
// per cycle (last vertex first, then every vertex in order, n the vertices
// stored) through a registered read port and two stages of edge arithmetic,
// and until those drain. The result then shows on done for exactly one cycle
// and must be taken then; the receiver cannot stall it. Unused action code 3 is
// taken and ignored. Vertex memory contents are undefined after reset and are
// only read below the stored count.
module point_in_polygon_test (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  pip_pkg::coord_t     coord_x,
    input  pip_pkg::coord_t     coord_y,
    output logic                done,
    output logic                inside_res,
    output pip_pkg::cnt_t       vertices_held,
    output logic                overflowed
);
    import pip_pkg::*;

    `include "point_in_polygon_test_assert.svh"

    // Vertex memory, x in the upper half, y in the lower half.
    logic [2*COORD_W-1:0] vmem [MAX_VERTICES];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic                 wr_en;
    addr_t                wr_addr;
    addr_t                rd_addr;

    state_t     state_reg, state_next;
    cnt_t       total_reg, total_next;
    logic       ovf_reg, ovf_next;
    cnt_t       k_reg, k_next;
    cnt_t       idx;
    logic       rd_vld_reg, rd_vld_next;
    logic       rd_first_reg, rd_first_next;
    coord_t     qx_reg, qx_next;
    coord_t     qy_reg, qy_next;
    coord_t     prev_x_reg, prev_y_reg;
    logic       done_reg, done_next;
    logic       res_in_reg, res_in_next;
    cnt_t       res_cnt_reg, res_cnt_next;
    logic       res_ovf_reg, res_ovf_next;
    logic       accept;
    logic       clear;
    logic       pair_vld;
    edge_stat_t stat;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign pair_vld = rd_vld_reg && !rd_first_reg;

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        done_next     = 1'b0;
        res_in_next   = res_in_reg;
        res_cnt_next  = res_cnt_reg;
        res_ovf_next  = res_ovf_reg;
        rd_vld_next   = 1'b0;
        rd_first_next = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        clear         = 1'b0;
        idx           = (k_reg == '0) ? total_reg - cnt_t'(1) : k_reg - cnt_t'(1);
        rd_addr       = idx[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_START:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            total_next = cnt_t'(1);
                            ovf_next   = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            if (total_reg < cnt_t'(MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = total_reg[ADDR_W-1:0];
                                total_next = total_reg + cnt_t'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_TEST:
                        begin
                            qx_next      = coord_x;
                            qy_next      = coord_y;
                            res_cnt_next = total_reg;
                            res_ovf_next = ovf_reg;
                            if (total_reg == '0)
                            begin
                                done_next   = 1'b1;
                                res_in_next = 1'b0;
                            end
                            else
                            begin
                                clear      = 1'b1;
                                k_next     = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            // drop the unused code
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Issue one read a cycle: last vertex first, then 0 .. n-1.
                rd_vld_next   = 1'b1;
                rd_first_next = (k_reg == '0);
                k_next        = k_reg + cnt_t'(1);
                if (k_reg == total_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && stat.idle)
                begin
                    done_next   = 1'b1;
                    res_in_next = stat.odd;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Writes happen only in idle and read data is used only while walking, so the
    // state machine itself keeps the two from touching the same entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vmem[wr_addr] <= {coord_x, coord_y};
        end
        rd_data_reg <= vmem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            k_reg        <= k_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        res_in_reg  <= res_in_next;
        res_cnt_reg <= res_cnt_next;
        res_ovf_reg <= res_ovf_next;
        // Hold the previous vertex of the walk.
        if (rd_vld_reg)
        begin
            prev_x_reg <= rd_data_reg[2*COORD_W-1:COORD_W];
            prev_y_reg <= rd_data_reg[COORD_W-1:0];
        end
    end

    pip_edge_unit u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clear),
        .pair_vld (pair_vld),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .xi       (rd_data_reg[2*COORD_W-1:COORD_W]),
        .yi       (rd_data_reg[COORD_W-1:0]),
        .xj       (prev_x_reg),
        .yj       (prev_y_reg),
        .stat     (stat)
    );

    assign done          = done_reg;
    assign inside_res    = res_in_reg;
    assign vertices_held = res_cnt_reg;
    assign overflowed    = res_ovf_reg;

    `PIP_ASSERT(a_done_single, done_reg |=> !done_reg)
    `PIP_NEVER(a_total_range, total_reg > cnt_t'(MAX_VERTICES))
    `PIP_ASSERT(a_write_idle, wr_en |-> (state_reg == ST_IDLE))
    `PIP_ASSERT(a_test_busy, (accept && action == ACT_TEST && total_reg != '0) |=> busy)

endmodule

// ===== verif/pip_checker.sv =====
`timescale 1ns / 100ps
// Watches the command and result channels of the polygon block, predicts and compares.
module pip_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic [1:0]      action,
    input  pip_pkg::coord_t coord_x,
    input  pip_pkg::coord_t coord_y,
    input  logic            done,
    input  logic            inside_res,
    input  pip_pkg::cnt_t   vertices_held,
    input  logic            overflowed,
    output int              fail_count,
    output int              outstanding
);
    import pip_pkg::*;

    typedef struct packed {
        logic hit;
        cnt_t held;
        logic ovf;
    } answer_t;

    coord_t  shape_x [MAX_VERTICES];
    coord_t  shape_y [MAX_VERTICES];
    int      shape_n;
    logic    shape_ovf;
    answer_t answers_due [$];

    // Even-odd parity over all edges, previous vertex to current, wrapping.
    function automatic logic crossing_parity(input coord_t qx, input coord_t qy);
        logic   parity;
        int     prev;
        longint xi, yi, xj, yj, dy, lhs, rhs;
        parity = 1'b0;
        prev   = shape_n - 1;
        for (int i = 0; i < shape_n; i++)
        begin
            xi = shape_x[i];
            yi = shape_y[i];
            xj = shape_x[prev];
            yj = shape_y[prev];
            if ((yi > longint'(qy)) != (yj > longint'(qy)))
            begin
                // compare qx against the crossing, multiplied out by dy
                dy  = yj - yi;
                lhs = (longint'(qx) - xi) * dy;
                rhs = (xj - xi) * (longint'(qy) - yi);
                if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                    parity = ~parity;
            end
            prev = i;
        end
        return parity;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            shape_n     = 0;
            shape_ovf   = 1'b0;
            answers_due.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: result with none expected: %s %0b %0d %0b", $time,
                             "inside_res vertices_held overflowed",
                             inside_res, vertices_held, overflowed);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (inside_res !== want.hit)
                    begin
                        $display("%0t: inside_res expected %0b actual %0b",
                                 $time, want.hit, inside_res);
                        fail_count++;
                    end
                    if (vertices_held !== want.held)
                    begin
                        $display("%0t: vertices_held expected %0d actual %0d",
                                 $time, want.held, vertices_held);
                        fail_count++;
                    end
                    if (overflowed !== want.ovf)
                    begin
                        $display("%0t: overflowed expected %0b actual %0b",
                                 $time, want.ovf, overflowed);
                        fail_count++;
                    end
                end
            end

            if (start && !busy)
            begin
                case (action)
                    ACT_START:
                    begin
                        shape_x[0] = coord_x;
                        shape_y[0] = coord_y;
                        shape_n    = 1;
                        shape_ovf  = 1'b0;
                    end
                    ACT_APPEND:
                    begin
                        if (shape_n < MAX_VERTICES)
                        begin
                            shape_x[shape_n] = coord_x;
                            shape_y[shape_n] = coord_y;
                            shape_n++;
                        end
                        else
                            shape_ovf = 1'b1;
                    end
                    ACT_TEST:
                    begin
                        want.hit  = (shape_n == 0) ? 1'b0 : crossing_parity(coord_x, coord_y);
                        want.held = cnt_t'(shape_n);
                        want.ovf  = shape_ovf;
                        answers_due = {answers_due, want};
                    end
                    default: ;
                endcase
            end
            outstanding = answers_due.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the point-in-polygon block: directed cases, overflow fill, random polygons.
module testbench;
    import pip_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         ITEM_GOAL  = 1950;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    coord_t      coord_x;
    coord_t      coord_y;
    logic        done;
    logic        inside_res;
    cnt_t        vertices_held;
    logic        overflowed;
    int          fail_count;
    int          outstanding;

    // Shadow of the polygon, used only to aim queries at interesting spots.
    coord_t      poly_x [MAX_VERTICES];
    coord_t      poly_y [MAX_VERTICES];
    int          poly_n;
    int          sent;
    logic        burst;

    point_in_polygon_test u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .done          (done),
        .inside_res    (inside_res),
        .vertices_held (vertices_held),
        .overflowed    (overflowed)
    );

    pip_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .done          (done),
        .inside_res    (inside_res),
        .vertices_held (vertices_held),
        .overflowed    (overflowed),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic coord_t pick_coord(input int mode);
        int v;
        case (mode)
            1:       v = int'($urandom_range(0, 4095)) - 2048;
            2:       v = (int'($urandom_range(0, 16)) - 8) * 256;
            3:
            begin
                case ($urandom_range(0, 6))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    5:       v = 32766;
                    default: v = 32767;
                endcase
            end
            default: v = int'($urandom);
        endcase
        return coord_t'(v);
    endfunction

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Drop start and hold off until every outstanding answer has come back.
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic issue(input logic [1:0] act, input coord_t x, input coord_t y);
        int r;
        start   <= 1'b1;
        action  <= act;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (act != ACT_UNUSED)
            sent++;
        if (act == ACT_START)
        begin
            poly_x[0] = x;
            poly_y[0] = y;
            poly_n    = 1;
        end
        else if (act == ACT_APPEND && poly_n < MAX_VERTICES)
        begin
            poly_x[poly_n] = x;
            poly_y[poly_n] = y;
            poly_n++;
        end
        if (!burst)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                pause(0);
            else if (r < 90)
                pause($urandom_range(1, 3));
            else if (r < 98)
                pause($urandom_range(4, 12));
            else
                pause($urandom_range(30, 150));
        end
    endtask

    initial
    begin
        int     vmode;
        int     verts;
        int     tests;
        int     r;
        int     a;
        int     b;
        logic   fresh;
        coord_t qx;
        coord_t qy;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        action  <= ACT_START;
        coord_x <= '0;
        coord_y <= '0;
        poly_n  = 0;
        sent    = 0;
        burst   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty polygon, append with no start, one and two vertices, unused code
        issue(ACT_TEST, 16'sd0, 16'sd0);
        issue(ACT_APPEND, 16'sd100, 16'sd200);
        issue(ACT_TEST, 16'sd0, 16'sd0);
        issue(ACT_APPEND, -16'sd100, -16'sd200);
        issue(ACT_TEST, 16'sd0, 16'sd0);
        issue(ACT_UNUSED, -16'sd1, -16'sd1);
        // full-range square
        issue(ACT_START, -16'sd32768, -16'sd32768);
        issue(ACT_APPEND, 16'sd32767, -16'sd32768);
        issue(ACT_APPEND, 16'sd32767, 16'sd32767);
        issue(ACT_APPEND, -16'sd32768, 16'sd32767);
        issue(ACT_TEST, 16'sd0, 16'sd0);
        issue(ACT_TEST, -16'sd32768, -16'sd32768);
        issue(ACT_TEST, 16'sd32767, 16'sd32767);
        issue(ACT_TEST, -16'sd32768, 16'sd0);
        issue(ACT_TEST, 16'sd32767, 16'sd0);
        issue(ACT_TEST, 16'sd0, -16'sd32768);
        issue(ACT_TEST, 16'sd0, 16'sd32767);
        issue(ACT_TEST, -16'sd32767, -16'sd32767);
        // small triangle with queries on two of its edges and one inside
        issue(ACT_START, 16'sd0, 16'sd0);
        issue(ACT_APPEND, 16'sd256, 16'sd0);
        issue(ACT_APPEND, 16'sd0, 16'sd256);
        issue(ACT_TEST, 16'sd0, 16'sd128);
        issue(ACT_TEST, 16'sd64, 16'sd64);
        issue(ACT_TEST, 16'sd255, 16'sd0);
        settle();

        // fill past capacity, then clear the overflow mark with a fresh start
        issue(ACT_START, pick_coord(1), pick_coord(1));
        for (int k = 0; k < MAX_VERTICES + 2; k++)
            issue(ACT_APPEND, pick_coord(1), pick_coord(1));
        issue(ACT_TEST, 16'sd0, 16'sd0);
        issue(ACT_TEST, pick_coord(1), pick_coord(1));
        issue(ACT_START, pick_coord(0), pick_coord(0));
        issue(ACT_TEST, pick_coord(0), pick_coord(0));
        settle();

        while (sent < ITEM_GOAL)
        begin
            vmode = $urandom_range(0, 3);
            burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 85)
                verts = $urandom_range(3, 10);
            else if (r < 95)
                verts = $urandom_range(11, 40);
            else
                verts = $urandom_range(60, 70);
            // now and then keep appending to the old polygon without a start
            fresh = ($urandom_range(0, 19) != 0);
            for (int k = 0; k < verts; k++)
            begin
                if ($urandom_range(0, 32) == 0)
                    issue(ACT_UNUSED, pick_coord(0), pick_coord(0));
                if ($urandom_range(0, 32) == 0)
                    issue(ACT_TEST, pick_coord(vmode), pick_coord(vmode));
                issue((k == 0 && fresh) ? ACT_START : ACT_APPEND,
                      pick_coord(vmode), pick_coord(vmode));
            end
            tests = $urandom_range(1, 6);
            for (int t = 0; t < tests; t++)
            begin
                a  = $urandom_range(0, poly_n - 1);
                b  = $urandom_range(0, poly_n - 1);
                qx = pick_coord(vmode);
                qy = pick_coord(vmode);
                case ($urandom_range(0, 4))
                    1: qy = poly_y[a];
                    2:
                    begin
                        qx = poly_x[a];
                        qy = poly_y[a];
                    end
                    3:
                    begin
                        qx = coord_t'((int'(poly_x[a]) + int'(poly_x[b])) / 2);
                        qy = coord_t'((int'(poly_y[a]) + int'(poly_y[b])) / 2);
                    end
                    4:
                    begin
                        qx = pick_coord(0);
                        qy = pick_coord(0);
                    end
                    default: ;
                endcase
                issue(ACT_TEST, qx, qy);
            end
            if ($urandom_range(0, 19) == 0)
                settle();
        end

        settle();
        repeat (80) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
